/* hdl/c2c_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// c2c_pkg
// shared constants, types and helpers of the coo to csr converter
// ----------------------------------------------------------------------------
package c2c_pkg;

	localparam int unsigned MAX_ROWS_DEF = 1024;
	localparam int unsigned MAX_NNZ_DEF  = 4096;
	localparam int unsigned COL_LIMIT    = 1024;
	localparam int unsigned COL_W        = 10;
	localparam int unsigned IDX_W        = 11;
	localparam int unsigned VAL_W        = 32;
	localparam int unsigned PTR_W        = 13;

	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_FETCH = 1'b1;

	localparam logic [1:0] REG_NUM_ROWS  = 2'd0;
	localparam logic [1:0] REG_NUM_COLS  = 2'd1;
	localparam logic [1:0] REG_ONE_BASED = 2'd2;

	localparam logic KIND_PTR   = 1'b0;
	localparam logic KIND_ENTRY = 1'b1;

	typedef struct packed {
		logic                 cmd;
		logic [IDX_W-1:0]     entry_row;
		logic [IDX_W-1:0]     entry_col;
		logic [VAL_W-1:0]     entry_value;
	} in_item_t;

	typedef struct packed {
		logic                 item_kind;
		logic [PTR_W-1:0]     row_pointer;
		logic [COL_W-1:0]     column;
		logic [VAL_W-1:0]     value;
		logic                 last;
		logic                 dropped_flag;
	} out_item_t;

	typedef struct packed {
		logic [1:0]  index;
		logic [31:0] data;
	} cfg_item_t;

	function automatic logic is_nan(input logic [31:0] b);
		return (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
	endfunction

	// float a < b, nan never less, zeros equal
	function automatic logic flt_less(input logic [31:0] a, input logic [31:0] b);
		logic [31:0] ka;
		logic [31:0] kb;
		ka = a[31] ? ~a : (a | 32'h8000_0000);
		kb = b[31] ? ~b : (b | 32'h8000_0000);
		if (is_nan(a) || is_nan(b))
			return 1'b0;
		if (a[30:0] == 31'd0 && b[30:0] == 31'd0)
			return 1'b0;
		return ka < kb;
	endfunction

endpackage : c2c_pkg
`default_nettype wire

/* hdl/c2c_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// c2c_stream_if
// valid/ready channel carrying one payload of a given type
// ----------------------------------------------------------------------------
interface c2c_stream_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface : c2c_stream_if
`default_nettype wire

/* hdl/coo_to_csr_diagonal_first_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// coo_to_csr_diagonal_first_core
// coordinate entries in, diagonal-first csr stream out
// ----------------------------------------------------------------------------
// A load reads its row head, walks its row's list (one entry store read per
// cycle) and writes the entry; a diagonal load goes straight to its row. A
// row pointer fetch is answered from the idle state, an entry fetch after one
// synchronous read. After reset and each final row pointer a clearing pass
// over all MAX_ROWS rows wipes the diagonal and row head memories; no
// transaction is accepted meanwhile; configuration writes are always taken.
module coo_to_csr_diagonal_first_core
	import c2c_pkg::*;
#(
	parameter int unsigned MAX_ROWS = MAX_ROWS_DEF,
	parameter int unsigned MAX_NNZ  = MAX_NNZ_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	c2c_stream_if.sink   cfg,
	c2c_stream_if.sink   in_ch,
	c2c_stream_if.source out_ch
);
	logic [IDX_W-1:0] num_rows_q, num_cols_q;
	logic             one_based_q;
	logic             busy;
	cfg_item_t        cfg_w;

	assign cfg.ready = 1'b1;
	assign cfg_w = cfg.payload;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_rows_q <= IDX_W'(1024); num_cols_q <= IDX_W'(1024); one_based_q <= 1'b0;
		end else if (cfg.valid) begin
			case (cfg_w.index)
				REG_NUM_ROWS:  num_rows_q  <= cfg_w.data[IDX_W-1:0];
				REG_NUM_COLS:  num_cols_q  <= cfg_w.data[IDX_W-1:0];
				REG_ONE_BASED: one_based_q <= cfg_w.data[0];
				default: ;
			endcase
		end
	end

	c2c_core #(.MAX_ROWS(MAX_ROWS), .MAX_NNZ(MAX_NNZ)) u_core (
		.clk, .arst_n,
		.in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_item(in_ch.payload),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_item(out_ch.payload),
		.num_rows(num_rows_q), .num_cols(num_cols_q), .one_based(one_based_q),
		.busy
	);

	// no input taken while a result waits
	a_no_in_with_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> !in_ch.ready) else $error("input taken with result pending");
	// busy while a result is pending
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> busy) else $error("not busy with result");

endmodule : coo_to_csr_diagonal_first_core
`default_nettype wire

/* hdl/c2c_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// c2c_core
// memories and sequencer: sorted list insertion, csr emission, clear sweep
// ----------------------------------------------------------------------------
module c2c_core
	import c2c_pkg::*;
#(
	parameter int unsigned MAX_ROWS = MAX_ROWS_DEF,
	parameter int unsigned MAX_NNZ  = MAX_NNZ_DEF
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	input  wire in_item_t  in_item,
	output logic           out_valid,
	input  wire logic      out_ready,
	output out_item_t      out_item,
	input  wire logic [IDX_W-1:0] num_rows,
	input  wire logic [IDX_W-1:0] num_cols,
	input  wire logic      one_based,
	output logic           busy
);
	localparam int unsigned RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int unsigned NW = (MAX_NNZ > 1) ? $clog2(MAX_NNZ) : 1;
	localparam int unsigned CW = NW + 1;
	localparam int unsigned EW = COL_W + VAL_W + NW + 1;

	localparam logic [3:0] ST_CLEAR  = 4'd0;
	localparam logic [3:0] ST_IDLE   = 4'd1;
	localparam logic [3:0] ST_HEAD   = 4'd2;
	localparam logic [3:0] ST_WALK   = 4'd3;
	localparam logic [3:0] ST_WRITE  = 4'd4;
	localparam logic [3:0] ST_FDIAG  = 4'd5;
	localparam logic [3:0] ST_FNODE  = 4'd6;
	localparam logic [3:0] ST_OUT    = 4'd7;

	localparam logic [1:0] PH_START = 2'd0;
	localparam logic [1:0] PH_DIAG  = 2'd1;
	localparam logic [1:0] PH_LIST  = 2'd2;

	// memories
	logic [VAL_W-1:0] diag_mem [MAX_ROWS];
	logic [NW:0]      head_mem [MAX_ROWS];   // {valid, index}
	logic [EW-1:0]    ent_mem  [MAX_NNZ];    // {col, value, next_valid, next}

	logic [VAL_W-1:0] diag_rd;
	logic [NW:0]      head_rd;
	logic [EW-1:0]    ent_rd;

	logic [3:0]       state_q;
	logic [RW-1:0]    clr_q;
	logic [1:0]       phase_q;
	logic [IDX_W-1:0] row_q;
	logic [NW-1:0]    node_q;
	logic             node_v_q;
	logic [PTR_W-1:0] off_q;
	logic [CW-1:0]    count_q;
	logic             drop_q;

	// load in flight
	logic [RW-1:0]    l_row_q;
	logic [COL_W-1:0] l_col_q;
	logic [VAL_W-1:0] l_val_q;
	logic [NW-1:0]    prev_q;
	logic             prev_v_q;
	logic [NW-1:0]    cur_q;
	logic             cur_v_q;
	out_item_t        out_q;
	logic             out_v_q;

	// memory control
	logic             d_we, h_we, e_we;
	logic [RW-1:0]    d_wa, h_wa, d_ra, h_ra;
	logic [VAL_W-1:0] d_wd;
	logic [NW:0]      h_wd;
	logic [NW-1:0]    e_wa, e_ra;
	logic [EW-1:0]    e_wd;
	logic             e_we2;
	logic [NW-1:0]    e_wa2;
	logic [NW:0]      e_link2;

	logic [IDX_W-1:0] eff_rows, eff_cols, r_c, c_c;
	logic             bad;
	logic             last_row;

	assign in_ready  = (state_q == ST_IDLE) && !out_v_q;
	assign out_valid = out_v_q;
	assign out_item  = out_q;
	assign busy      = (state_q != ST_IDLE) || out_v_q;

	// effective limits and corrected indexes
	always_comb begin
		eff_rows = (num_rows < IDX_W'(MAX_ROWS)) || (MAX_ROWS >= 2048) ? num_rows
		         : IDX_W'(MAX_ROWS);
		eff_cols = (num_cols < IDX_W'(COL_LIMIT)) ? num_cols : IDX_W'(COL_LIMIT);
		r_c = in_item.entry_row - IDX_W'(one_based);
		c_c = in_item.entry_col - IDX_W'(one_based);
		bad = (one_based && (in_item.entry_row == '0 || in_item.entry_col == '0))
		   || (r_c >= eff_rows) || (c_c >= eff_cols);
		last_row = (row_q + 1'b1) >= eff_rows;
	end

	// memory ports
	always_ff @(posedge clk) begin
		if (d_we) diag_mem[d_wa] <= d_wd;
		if (h_we) head_mem[h_wa] <= h_wd;
		if (e_we) ent_mem[e_wa] <= e_wd;
		if (e_we2) ent_mem[e_wa2][NW:0] <= e_link2;
		diag_rd <= diag_mem[d_ra];
		head_rd <= head_mem[h_ra];
		ent_rd  <= ent_mem[e_ra];
	end

	// write and read address selection
	always_comb begin
		d_we = 1'b0; d_wa = clr_q; d_wd = '0;
		h_we = 1'b0; h_wa = clr_q; h_wd = '0;
		e_we = 1'b0; e_wa = count_q[NW-1:0];
		e_wd = {l_col_q, l_val_q, cur_v_q, cur_q};
		e_we2 = 1'b0; e_wa2 = prev_q; e_link2 = {1'b1, count_q[NW-1:0]};
		d_ra = r_c[RW-1:0]; h_ra = r_c[RW-1:0]; e_ra = cur_q;
		case (state_q)
			ST_CLEAR: begin
				d_we = 1'b1; h_we = 1'b1;
			end
			ST_IDLE: begin
				if (in_item.cmd == CMD_FETCH) begin
					d_ra = row_q[RW-1:0]; h_ra = row_q[RW-1:0];
				end
				e_ra = node_q;
				// diagonal load goes straight to its row
				if (in_valid && in_ready && in_item.cmd == CMD_LOAD &&
				    phase_q == PH_START && !bad && r_c == c_c) begin
					d_we = 1'b1; d_wa = r_c[RW-1:0]; d_wd = in_item.entry_value;
				end
			end
			ST_HEAD, ST_WALK: e_ra = ent_rd[NW-1:0];
			ST_WRITE: begin
				e_we = 1'b1;
				if (prev_v_q) e_we2 = 1'b1;
				else begin
					h_we = 1'b1; h_wa = l_row_q; h_wd = {1'b1, count_q[NW-1:0]};
				end
			end
			default: ;
		endcase
		if (state_q == ST_HEAD) e_ra = head_rd[NW-1:0];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR; clr_q <= '0; phase_q <= PH_START;
			row_q <= '0; node_q <= '0; node_v_q <= 1'b0; off_q <= '0;
			count_q <= '0; drop_q <= 1'b0; out_v_q <= 1'b0; out_q <= '0;
			l_row_q <= '0; l_col_q <= '0; l_val_q <= '0;
			prev_q <= '0; prev_v_q <= 1'b0; cur_q <= '0; cur_v_q <= 1'b0;
		end else begin
			if (out_v_q && out_ready) out_v_q <= 1'b0;
			case (state_q)
				ST_CLEAR: begin
					if (clr_q == RW'(MAX_ROWS - 1)) begin
						clr_q <= '0; state_q <= ST_IDLE;
					end else clr_q <= clr_q + 1'b1;
				end
				ST_IDLE: begin
					if (in_valid && in_ready) begin
						if (in_item.cmd == CMD_LOAD) begin
							l_row_q <= r_c[RW-1:0]; l_col_q <= c_c[COL_W-1:0];
							l_val_q <= in_item.entry_value;
							if (phase_q != PH_START || bad) drop_q <= 1'b1;
							else if (r_c != c_c) begin
								if (count_q >= CW'(MAX_NNZ)) drop_q <= 1'b1;
								else begin
									prev_v_q <= 1'b0; state_q <= ST_HEAD;
								end
							end
						end else begin
							case (phase_q)
								PH_START: begin
									off_q <= '0; out_v_q <= 1'b1;
									out_q <= {KIND_PTR, {PTR_W{1'b0}}, {COL_W{1'b0}},
										{VAL_W{1'b0}}, (eff_rows == '0), drop_q};
									if (eff_rows == '0) begin
										state_q <= ST_CLEAR;
										phase_q <= PH_START; count_q <= '0;
										drop_q <= 1'b0; row_q <= '0;
									end else begin
										phase_q <= PH_DIAG; row_q <= '0;
									end
								end
								PH_DIAG: state_q <= ST_FDIAG;
								default: begin
									if (node_v_q) state_q <= ST_FNODE;
									else begin
										out_v_q <= 1'b1;
										out_q <= {KIND_PTR, off_q, {COL_W{1'b0}},
											{VAL_W{1'b0}}, last_row, drop_q};
										if (last_row) begin
											state_q <= ST_CLEAR;
											phase_q <= PH_START; count_q <= '0;
											drop_q <= 1'b0; row_q <= '0; off_q <= '0;
										end else begin
											row_q <= row_q + 1'b1; phase_q <= PH_DIAG;
										end
									end
								end
							endcase
						end
					end
				end
				ST_HEAD: begin
					cur_v_q <= head_rd[NW]; cur_q <= head_rd[NW-1:0];
					state_q <= head_rd[NW] ? ST_WALK : ST_WRITE;
				end
				ST_WALK: begin
					// ent_rd holds entry cur_q
					if (ent_rd[EW-1 -: COL_W] > l_col_q ||
					    (ent_rd[EW-1 -: COL_W] == l_col_q &&
					     flt_less(l_val_q, ent_rd[NW+1 +: VAL_W]))) begin
						state_q <= ST_WRITE;
					end else begin
						prev_q <= cur_q; prev_v_q <= 1'b1;
						cur_v_q <= ent_rd[NW]; cur_q <= ent_rd[NW-1:0];
						state_q <= ent_rd[NW] ? ST_WALK : ST_WRITE;
					end
				end
				ST_WRITE: begin
					count_q <= count_q + 1'b1; state_q <= ST_IDLE;
				end
				ST_FDIAG: begin
					out_q <= {KIND_ENTRY, {PTR_W{1'b0}}, row_q[COL_W-1:0], diag_rd,
						1'b0, drop_q};
					out_v_q <= 1'b1; off_q <= off_q + 1'b1;
					node_v_q <= head_rd[NW]; node_q <= head_rd[NW-1:0];
					phase_q <= PH_LIST; state_q <= ST_IDLE;
				end
				ST_FNODE: begin
					out_q <= {KIND_ENTRY, {PTR_W{1'b0}}, ent_rd[EW-1 -: COL_W],
						ent_rd[NW+1 +: VAL_W], 1'b0, drop_q};
					out_v_q <= 1'b1; off_q <= off_q + 1'b1;
					node_v_q <= ent_rd[NW]; node_q <= ent_rd[NW-1:0];
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule : c2c_core
`default_nettype wire

/* bench/coo_to_csr_diagonal_first_core_checker.sv */
// ----------------------------------------------------------------------------
// coo_to_csr_diagonal_first_core_checker
// Watches the configuration, command and result channels of the converter.
// It keeps its own copy of the matrix lists, works out the csr item that each
// accepted fetch must return, and compares every result field by field.
// ----------------------------------------------------------------------------
module coo_to_csr_diagonal_first_core_checker
	import c2c_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cfg_valid,
	input  logic      cfg_ready,
	input  cfg_item_t cfg_data,
	input  logic      in_valid,
	input  logic      in_ready,
	input  in_item_t  in_data,
	input  logic      out_valid,
	input  logic      out_ready,
	input  out_item_t out_data,
	output int        fail_count,
	output int        pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef enum int {WALK_START, WALK_DIAG, WALK_LIST} walk_e;

	// configuration copy
	int unsigned rows_reg, cols_reg;
	bit          one_based_reg;

	// matrix copy
	logic [31:0] diag_val [MAX_ROWS_DEF];
	int unsigned node_col [MAX_NNZ_DEF];
	logic [31:0] node_val [MAX_NNZ_DEF];
	int unsigned node_next [MAX_NNZ_DEF];
	bit          node_has_next [MAX_NNZ_DEF];
	int unsigned row_head [MAX_ROWS_DEF];
	bit          row_has_head [MAX_ROWS_DEF];
	int unsigned stored;
	bit          any_dropped;

	// emission position
	walk_e       walk;
	int unsigned walk_row, walk_node, walk_offset;
	bit          walk_node_ok;

	out_item_t   csr_expected [$];

	function automatic int unsigned rows_used();
		return rows_reg < MAX_ROWS_DEF ? rows_reg : MAX_ROWS_DEF;
	endfunction

	function automatic int unsigned cols_used();
		return cols_reg < COL_LIMIT ? cols_reg : COL_LIMIT;
	endfunction

	function automatic bit not_a_number(logic [31:0] b);
		return b[30:23] == 8'hFF && b[22:0] != 0;
	endfunction

	// strict float order on bit patterns, nan unordered, signed zeros equal
	function automatic bit sorts_below(logic [31:0] a, logic [31:0] b);
		logic [31:0] ka, kb;
		if (not_a_number(a) || not_a_number(b))
			return 0;
		if (a[30:0] == 0 && b[30:0] == 0)
			return 0;
		ka = a[31] ? ~a : {1'b1, a[30:0]};
		kb = b[31] ? ~b : {1'b1, b[30:0]};
		return ka < kb;
	endfunction

	function automatic void wipe_matrix();
		for (int i = 0; i < MAX_ROWS_DEF; i++) begin
			diag_val[i] = 0;
			row_head[i] = 0;
			row_has_head[i] = 0;
		end
		stored = 0;
		any_dropped = 0;
		walk = WALK_START;
		walk_row = 0;
		walk_node = 0;
		walk_node_ok = 0;
		walk_offset = 0;
	endfunction

	// sorted insertion of one coordinate entry
	function automatic void insert_entry(int unsigned r, int unsigned c, logic [31:0] v);
		int unsigned cur, prev;
		bit cur_ok, prev_ok;
		prev = 0;
		prev_ok = 0;
		if (walk != WALK_START) begin
			any_dropped = 1;
			return;
		end
		if (one_based_reg) begin
			if (r == 0 || c == 0) begin
				any_dropped = 1;
				return;
			end
			r--;
			c--;
		end
		if (r >= rows_used() || c >= cols_used()) begin
			any_dropped = 1;
			return;
		end
		if (r == c) begin
			diag_val[r] = v;
			return;
		end
		if (stored >= MAX_NNZ_DEF) begin
			any_dropped = 1;
			return;
		end
		cur = row_head[r];
		cur_ok = row_has_head[r];
		while (cur_ok) begin
			if (node_col[cur] > c || (node_col[cur] == c && sorts_below(v, node_val[cur])))
				break;
			prev = cur;
			prev_ok = 1;
			cur_ok = node_has_next[cur];
			cur = node_next[cur];
		end
		node_col[stored] = c;
		node_val[stored] = v;
		node_next[stored] = cur;
		node_has_next[stored] = cur_ok;
		if (prev_ok) begin
			node_next[prev] = stored;
			node_has_next[prev] = 1;
		end else begin
			row_head[r] = stored;
			row_has_head[r] = 1;
		end
		stored++;
	endfunction

	// next item of the csr stream
	function automatic out_item_t next_csr_item();
		out_item_t o;
		int unsigned r;
		bit done;
		o = '0;
		done = 0;
		o.dropped_flag = any_dropped;
		case (walk)
			WALK_START: begin
				walk_offset = 0;
				if (rows_used() == 0) begin
					o.last = 1;
					done = 1;
				end else begin
					walk = WALK_DIAG;
					walk_row = 0;
				end
			end
			WALK_DIAG: begin
				r = walk_row < MAX_ROWS_DEF ? walk_row : 0;
				o.item_kind = KIND_ENTRY;
				o.column = r[COL_W-1:0];
				o.value = diag_val[r];
				walk_offset++;
				walk_node = row_head[r];
				walk_node_ok = row_has_head[r];
				walk = WALK_LIST;
			end
			default: begin
				if (walk_node_ok && walk_node < MAX_NNZ_DEF) begin
					o.item_kind = KIND_ENTRY;
					o.column = node_col[walk_node][COL_W-1:0];
					o.value = node_val[walk_node];
					walk_offset++;
					walk_node_ok = node_has_next[walk_node];
					walk_node = node_next[walk_node];
				end else begin
					o.item_kind = KIND_PTR;
					o.row_pointer = walk_offset[PTR_W-1:0];
					if (walk_row + 1 >= rows_used()) begin
						o.last = 1;
						done = 1;
					end else begin
						walk_row++;
						walk = WALK_DIAG;
					end
				end
			end
		endcase
		if (done)
			wipe_matrix();
		return o;
	endfunction

	function automatic void compare_field(string name, longint unsigned exp_v,
			longint unsigned act_v);
		if (exp_v != act_v) begin
			$error("%s: expected %0h, actual %0h", name, exp_v, act_v);
			fail_count++;
		end
	endfunction

	// results are compared before new commands are predicted
	always @(posedge clk or negedge arst_n) begin
		out_item_t e;
		out_item_t nx;
		if (!arst_n) begin
			rows_reg = 1024;
			cols_reg = 1024;
			one_based_reg = 0;
			wipe_matrix();
			csr_expected.delete();
			fail_count = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (csr_expected.size() == 0) begin
					$error("result transaction with nothing expected");
					fail_count++;
				end else begin
					e = csr_expected.pop_front();
					compare_field("item_kind", e.item_kind, out_data.item_kind);
					compare_field("row_pointer", e.row_pointer, out_data.row_pointer);
					compare_field("column", e.column, out_data.column);
					compare_field("value", e.value, out_data.value);
					compare_field("last", e.last, out_data.last);
					compare_field("dropped_flag", e.dropped_flag, out_data.dropped_flag);
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_data.index)
					REG_NUM_ROWS:  rows_reg = cfg_data.data[10:0];
					REG_NUM_COLS:  cols_reg = cfg_data.data[10:0];
					REG_ONE_BASED: one_based_reg = cfg_data.data[0];
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				if (in_data.cmd == CMD_LOAD)
					insert_entry(in_data.entry_row, in_data.entry_col, in_data.entry_value);
				else begin
					nx = next_csr_item();
					csr_expected = {csr_expected, nx};
				end
			end
		end
		pending = csr_expected.size();
	end

endmodule : coo_to_csr_diagonal_first_core_checker

/* bench/coo_to_csr_diagonal_first_core_test.sv */
// ----------------------------------------------------------------------------
// coo_to_csr_diagonal_first_core_test
// Loads sparse matrices with random and corner-case entries under several
// configurations and idle patterns, fetches each csr stream to its end, and
// reports the verdict of the checker.
// ----------------------------------------------------------------------------
module coo_to_csr_diagonal_first_core_test;
	import c2c_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam longint CYCLE_LIMIT = 3_000_000;

	logic clk = 0;
	logic arst_n = 0;
	int   fail_count, pending;
	longint cycles = 0;
	int   idle_pct = 0, stall_pct = 0;

	// bench copy of what decides the stream length
	int unsigned rows_set = 1024, cols_set = 1024;
	bit          one_based_set = 0;
	int unsigned kept_entries = 0;
	int unsigned kept_row [1024];
	int          random_items = 0;
	bit          in_random = 0;

	c2c_stream_if #(.T(cfg_item_t)) cfg_ch ();
	c2c_stream_if #(.T(in_item_t))  in_ch ();
	c2c_stream_if #(.T(out_item_t)) out_ch ();

	coo_to_csr_diagonal_first_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	coo_to_csr_diagonal_first_core_checker checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_ch.valid),
		.cfg_ready  (cfg_ch.ready),
		.cfg_data   (cfg_ch.payload),
		.in_valid   (in_ch.valid),
		.in_ready   (in_ch.ready),
		.in_data    (in_ch.payload),
		.out_valid  (out_ch.valid),
		.out_ready  (out_ch.ready),
		.out_data   (out_ch.payload),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always begin
		#10 clk = 1;
		#10 clk = 0;
	end

	// receiver stalls
	always @(negedge clk)
		out_ch.ready <= ($urandom_range(99) >= stall_pct);

	// run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("coo_to_csr_diagonal_first_core: mismatch");
			$finish;
		end
	end

	function automatic int unsigned rows_eff();
		return rows_set < 1024 ? rows_set : 1024;
	endfunction

	function automatic int unsigned cols_eff();
		return cols_set < 1024 ? cols_set : 1024;
	endfunction

	// float patterns with zeros, nans, infinities and repeated values
	function automatic logic [31:0] pick_value();
		case ($urandom_range(9))
			0: return 32'h0000_0000;
			1: return 32'h8000_0000;
			2: return {1'($urandom_range(1)), 8'hFF, 23'($urandom_range(32'h7F_FFFF, 1))};
			3: return $urandom_range(1) ? 32'h7F80_0000 : 32'hFF80_0000;
			4: return 32'h3F80_0000;
			5: return 32'hBF80_0000;
			default: return $urandom;
		endcase
	endfunction

	task automatic wait_drained();
		while (pending != 0)
			@(negedge clk);
	endtask

	task automatic push_item(input logic c, input logic [10:0] r, input logic [10:0] col,
			input logic [31:0] v);
		if ($urandom_range(99) < idle_pct) begin
			in_ch.valid <= 0;
			repeat ($urandom_range(4, 1)) @(negedge clk);
		end
		in_ch.valid <= 1;
		in_ch.payload <= '{cmd: c, entry_row: r, entry_col: col, entry_value: v};
		do @(posedge clk); while (!in_ch.ready);
		@(negedge clk);
		if (in_random)
			random_items++;
	endtask

	// load one entry, tracking whether it lands in the list store
	task automatic load_entry(input logic [10:0] r, input logic [10:0] c, input logic [31:0] v);
		int unsigned rr, cc;
		bit ok;
		rr = r;
		cc = c;
		ok = 1;
		if (one_based_set) begin
			if (rr == 0 || cc == 0)
				ok = 0;
			rr--;
			cc--;
		end
		if (ok && rr < rows_eff() && cc < cols_eff() && rr != cc && kept_entries < 4096) begin
			kept_entries++;
			kept_row[rr]++;
		end
		push_item(CMD_LOAD, r, c, v);
	endtask

	// fetch the whole stream; optionally a dropped load or a drain pause midway
	task automatic fetch_matrix(input bit load_inside, input bit drain_inside);
		int n;
		int unsigned rows_n;
		rows_n = rows_eff();
		n = 1 + 2 * rows_n;
		for (int k = 0; k < rows_n; k++)
			n += int'(kept_row[k]);
		for (int i = 0; i < n; i++) begin
			if (i == n / 2 && i > 0) begin
				if (load_inside)
					push_item(CMD_LOAD, 0, 1, pick_value());
				if (drain_inside) begin
					in_ch.valid <= 0;
					wait_drained();
				end
			end
			push_item(CMD_FETCH, 11'($urandom), 11'($urandom), $urandom);
		end
		kept_entries = 0;
		foreach (kept_row[k])
			kept_row[k] = 0;
	endtask

	task automatic write_reg(input logic [1:0] idx, input int unsigned data);
		in_ch.valid <= 0;
		wait_drained();
		repeat (64) @(negedge clk);
		cfg_ch.valid <= 1;
		cfg_ch.payload <= '{index: idx, data: data};
		do @(posedge clk); while (!cfg_ch.ready);
		@(negedge clk);
		cfg_ch.valid <= 0;
		case (idx)
			REG_NUM_ROWS:  rows_set = data & 11'h7FF;
			REG_NUM_COLS:  cols_set = data & 11'h7FF;
			default:       one_based_set = data[0];
		endcase
	endtask

	task automatic configure(input int unsigned r, input int unsigned c, input bit ob);
		write_reg(REG_NUM_ROWS, r);
		write_reg(REG_NUM_COLS, c);
		write_reg(REG_ONE_BASED, ob);
	endtask

	task automatic pick_idling();
		case ($urandom_range(3))
			0: begin idle_pct = 0;  stall_pct = 0;  end
			1: begin idle_pct = 56; stall_pct = 0;  end
			2: begin idle_pct = 0;  stall_pct = 56; end
			default: begin idle_pct = 23; stall_pct = 23; end
		endcase
	endtask

	// mostly in-range indexes with repeated columns, some full-width noise
	function automatic logic [10:0] pick_index();
		int unsigned span;
		span = (rows_eff() > cols_eff() ? rows_eff() : cols_eff()) + one_based_set;
		if ($urandom_range(99) < 8)
			return 11'($urandom_range(2047));
		return 11'($urandom_range(span));
	endfunction

	initial begin
		int unsigned r, c;
		int loads;
		cfg_ch.valid = 0;
		cfg_ch.payload = '0;
		in_ch.valid = 0;
		in_ch.payload = '0;
		out_ch.ready = 0;
		repeat (5) @(negedge clk);
		arst_n = 1;

		// reset configuration: extremes of the indexes, diagonal overwrite,
		// out-of-range drops, nan and signed zeros sharing one column;
		// the stream is then cut to the first rows
		load_entry(0, 0, 32'h4000_0000);
		load_entry(0, 0, 32'hC000_0000);
		load_entry(1023, 1023, 32'hFFFF_FFFF);
		load_entry(0, 1023, 32'h3F80_0000);
		load_entry(1023, 0, 32'h0000_0001);
		load_entry(1, 5, 32'h7FC0_0000);
		load_entry(1, 5, 32'h8000_0000);
		load_entry(1, 5, 32'h0000_0000);
		load_entry(1, 5, 32'hBF80_0000);
		load_entry(1, 5, 32'h7F80_0000);
		load_entry(1, 2, 32'h3F80_0000);
		load_entry(2, 1024, 32'h1);
		load_entry(2047, 3, 32'h2);
		configure(3, 1024, 0);
		fetch_matrix(0, 0);

		// one-based indexes, zero index dropped, load during emission dropped
		configure(3, 3, 1);
		load_entry(0, 1, 32'h1);
		load_entry(1, 1, 32'h3F80_0000);
		load_entry(3, 3, 32'h4040_0000);
		load_entry(2, 1, 32'h4000_0000);
		load_entry(3, 4, 32'h5);
		fetch_matrix(1, 1);

		// no rows
		configure(0, 2047, 0);
		load_entry(0, 1, 32'h1);
		fetch_matrix(0, 0);

		// random matrices
		in_random = 1;
		for (int m = 0; random_items < 1250; m++) begin
			pick_idling();
			if (m % 30 == 15)
				configure($urandom_range(40, 9), $urandom_range(1024, 1), $urandom_range(1));
			else
				configure($urandom_range(8, 1), $urandom_range(8, 1), $urandom_range(1));
			loads = $urandom_range(20);
			for (int i = 0; i < loads; i++) begin
				r = pick_index();
				c = $urandom_range(99) < 20 ? r : pick_index();
				load_entry(r, c, pick_value());
			end
			fetch_matrix($urandom_range(99) < 10, m % 9 == 4);
		end

		in_ch.valid <= 0;
		wait_drained();
		repeat (50) @(posedge clk);
		if (fail_count == 0)
			$display("coo_to_csr_diagonal_first_core: match");
		else
			$display("coo_to_csr_diagonal_first_core: mismatch");
		$finish;
	end

endmodule : coo_to_csr_diagonal_first_core_test

/* files.f */
hdl/c2c_pkg.sv
hdl/c2c_if.sv
hdl/c2c_core.sv
hdl/coo_to_csr_diagonal_first_core.sv
bench/coo_to_csr_diagonal_first_core_checker.sv
bench/coo_to_csr_diagonal_first_core_test.sv
